[design/stl_pkg.sv]
package stl_pkg;

   localparam int POS_BITS = 32;
   localparam int Q_DEPTH = 4;
   localparam int Q_PTR_BITS = $clog2(Q_DEPTH);

   typedef enum logic [3:0] {
      M_IDLE, M_NUM_INT, M_NUM_DEC, M_NUM_INT_DOT, M_NUM_DEC_DOT,
      M_IDENT, M_OP, M_LINE, M_BLOCK, M_BLOCK_STAR, M_DROP
   } lex_mode_type;

   typedef enum logic [2:0] {
      K_NEWLINE, K_OP, K_SYMBOL, K_KEYWORD, K_NUMBER, K_IDENT, K_END, K_ERROR
   } kind_type;

   localparam logic CMD_BYTE = 1'b0;
   localparam logic CMD_END  = 1'b1;

   localparam logic [4:0] ERR_UNKNOWN = 5'd0;
   localparam logic [4:0] ERR_DOT2    = 5'd1;
   localparam logic [4:0] ERR_BLOCK   = 5'd2;
   localparam logic [4:0] OP_RANGE    = 5'd9;

   // keyword text, left-padded packed bytes, and lengths
   localparam logic [47:0] KW_TEXT [5] = '{
      48'h617363656e74, 48'h0066616c7365, 48'h0000656c7365,
      48'h000074727565, 48'h000000006966 };
   localparam logic [2:0] KW_LEN [5] = '{3'd6, 3'd5, 3'd4, 3'd4, 3'd2};

   typedef struct packed {
      logic       cmd;
      logic [7:0] source_byte;
   } stl_req_type;

   typedef struct packed {
      logic [2:0]  token_kind;
      logic [4:0]  token_subtype;
      logic [31:0] token_start;
      logic [31:0] token_length;
      logic [31:0] line_number;
      logic        last_of_run;
   } stl_rsp_type;

   // {hit, code} for a two-character operator
   function automatic logic [5:0] pair_code(input logic [7:0] h, input logic [7:0] b);
      logic [5:0] r;
      r = '0;
      if (b == "=") begin
         case (h)
            "=": r = {1'b1, 5'd0};
            "!": r = {1'b1, 5'd1};
            "<": r = {1'b1, 5'd2};
            ">": r = {1'b1, 5'd3};
            "+": r = {1'b1, 5'd4};
            "-": r = {1'b1, 5'd5};
            "*": r = {1'b1, 5'd6};
            "/": r = {1'b1, 5'd7};
            "%": r = {1'b1, 5'd8};
            default: r = '0;
         endcase
      end
      if (h == "." && b == ".") r = {1'b1, OP_RANGE};
      if (h == "&" && b == "&") r = {1'b1, 5'd10};
      if (h == "|" && b == "|") r = {1'b1, 5'd11};
      return r;
   endfunction

   function automatic logic [5:0] single_code(input logic [7:0] h);
      logic [5:0] r;
      case (h)
         "+": r = {1'b1, 5'd12};
         "-": r = {1'b1, 5'd13};
         "*": r = {1'b1, 5'd14};
         "/": r = {1'b1, 5'd15};
         "%": r = {1'b1, 5'd16};
         "=": r = {1'b1, 5'd17};
         ".": r = {1'b1, 5'd18};
         "!": r = {1'b1, 5'd19};
         "<": r = {1'b1, 5'd20};
         ">": r = {1'b1, 5'd21};
         default: r = '0;
      endcase
      return r;
   endfunction

   function automatic logic [5:0] symbol_code(input logic [7:0] b);
      logic [5:0] r;
      case (b)
         "(": r = {1'b1, 5'd0};
         ")": r = {1'b1, 5'd1};
         "{": r = {1'b1, 5'd2};
         "}": r = {1'b1, 5'd3};
         ",": r = {1'b1, 5'd4};
         "@": r = {1'b1, 5'd5};
         default: r = '0;
      endcase
      return r;
   endfunction

   function automatic logic is_digit(input logic [7:0] b);
      return b >= "0" && b <= "9";
   endfunction

   function automatic logic is_alpha(input logic [7:0] b);
      return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == "_";
   endfunction

endpackage

[design/stl_core.sv]
module stl_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_fire,
   input  stl_pkg::stl_req_type req_item,
   output logic [1:0]           tok_valid,
   output stl_pkg::stl_rsp_type tok0,
   output stl_pkg::stl_rsp_type tok1
);
   import stl_pkg::*;

   lex_mode_type        mode_ff, mode_in;
   logic [7:0]          held_ff, held_in;
   logic [POS_BITS-1:0] pos_ff, pos_in, start_ff, start_in;
   logic [31:0]         line_ff, line_in;
   logic [47:0]         prefix_ff, prefix_in;
   logic [2:0]          wlen_ff, wlen_in;

   function automatic stl_rsp_type mk(input kind_type k, input logic [4:0] s,
                                      input logic [31:0] st, input logic [31:0] ln,
                                      input logic [31:0] line);
      stl_rsp_type t;
      t.token_kind = k;
      t.token_subtype = s;
      t.token_start = st;
      t.token_length = ln;
      t.line_number = line;
      t.last_of_run = 1'b0;
      return t;
   endfunction

   // next state and up to two tokens for the request
   always_comb begin
      logic [7:0]          b;
      logic [POS_BITS-1:0] pos;
      logic                do_fresh, lup, v0, v1;
      stl_rsp_type         t0, t1, w, f;
      logic                fv;
      logic [5:0]          sc, pc, yc;
      b = req_item.source_byte;
      pos = pos_ff;
      do_fresh = 1'b0;
      lup = 1'b0;
      v0 = 1'b0;
      v1 = 1'b0;
      t0 = '0;
      t1 = '0;
      f = '0;
      fv = 1'b0;
      mode_in = mode_ff;
      held_in = held_ff;
      pos_in = pos_ff;
      start_in = start_ff;
      line_in = line_ff;
      prefix_in = prefix_ff;
      wlen_in = wlen_ff;
      sc = single_code(held_ff);
      pc = pair_code(held_ff, b);
      yc = symbol_code(b);

      // identifier or keyword token ending at this position
      w = mk(K_IDENT, 5'd0, start_ff, pos - start_ff, line_ff);
      for (int k = 4; k >= 0; k--) begin
         if (wlen_ff == KW_LEN[k] && prefix_ff == KW_TEXT[k]) begin
            w.token_kind = K_KEYWORD;
            w.token_subtype = 5'(k);
         end
      end

      if (req_item.cmd == CMD_END) begin
         v0 = 1'b1;
         case (mode_ff)
            M_NUM_INT: t0 = mk(K_NUMBER, 5'd0, start_ff, pos - start_ff, line_ff);
            M_NUM_DEC, M_NUM_INT_DOT:
               t0 = mk(K_NUMBER, 5'd1, start_ff, pos - start_ff, line_ff);
            M_NUM_DEC_DOT: t0 = mk(K_ERROR, ERR_DOT2, start_ff, pos - start_ff, line_ff);
            M_IDENT: t0 = w;
            M_OP: begin
               if (sc[5]) t0 = mk(K_OP, sc[4:0], start_ff, 32'd1, line_ff);
               else t0 = mk(K_ERROR, ERR_UNKNOWN, start_ff, 32'd1, line_ff);
            end
            M_BLOCK, M_BLOCK_STAR:
               t0 = mk(K_ERROR, ERR_BLOCK, start_ff, pos - start_ff, line_ff);
            default: v0 = 1'b0;
         endcase
         if (v0) begin
            v1 = 1'b1;
            t1 = mk(K_END, 5'd0, pos, 32'd0, line_ff);
         end else begin
            v0 = 1'b1;
            t0 = mk(K_END, 5'd0, pos, 32'd0, line_ff);
         end
         mode_in = M_IDLE;
         held_in = '0;
         pos_in = '0;
         start_in = '0;
         line_in = 32'd1;
         prefix_in = '0;
         wlen_in = '0;
      end else begin
         pos_in = pos + 1'b1;
         case (mode_ff)
            M_NUM_INT, M_NUM_DEC, M_NUM_INT_DOT: begin
               if (mode_ff == M_NUM_INT_DOT) mode_in = M_NUM_DEC;
               if (mode_ff == M_NUM_INT_DOT && b == ".") begin
                  v0 = 1'b1;
                  v1 = 1'b1;
                  t0 = mk(K_NUMBER, 5'd0, start_ff, (pos - 1'b1) - start_ff, line_ff);
                  t1 = mk(K_OP, OP_RANGE, pos - 1'b1, 32'd2, line_ff);
                  mode_in = M_IDLE;
               end else if (is_digit(b)) begin
                  // number continues
               end else if (b == ".") begin
                  mode_in = (mode_ff == M_NUM_INT) ? M_NUM_INT_DOT : M_NUM_DEC_DOT;
               end else begin
                  v0 = 1'b1;
                  t0 = mk(K_NUMBER, {4'd0, mode_ff != M_NUM_INT}, start_ff,
                          pos - start_ff, line_ff);
                  do_fresh = 1'b1;
               end
            end
            M_NUM_DEC_DOT: begin
               v0 = 1'b1;
               if (b == ".") begin
                  v1 = 1'b1;
                  t0 = mk(K_NUMBER, 5'd1, start_ff, (pos - 1'b1) - start_ff, line_ff);
                  t1 = mk(K_OP, OP_RANGE, pos - 1'b1, 32'd2, line_ff);
                  mode_in = M_IDLE;
               end else begin
                  t0 = mk(K_ERROR, ERR_DOT2, start_ff, pos - start_ff, line_ff);
                  mode_in = M_DROP;
               end
            end
            M_IDENT: begin
               if (is_alpha(b) || is_digit(b)) begin
                  if (wlen_ff < 3'd6) prefix_in = {prefix_ff[39:0], b};
                  if (wlen_ff < 3'd7) wlen_in = wlen_ff + 1'b1;
               end else begin
                  v0 = 1'b1;
                  t0 = w;
                  do_fresh = 1'b1;
               end
            end
            M_OP: begin
               if (pc[5]) begin
                  v0 = 1'b1;
                  t0 = mk(K_OP, pc[4:0], start_ff, 32'd2, line_ff);
                  mode_in = M_IDLE;
               end else if (held_ff == "/" && b == "/") begin
                  mode_in = M_LINE;
               end else if (held_ff == "/" && b == "*") begin
                  mode_in = M_BLOCK;
               end else if (!sc[5]) begin
                  v0 = 1'b1;
                  t0 = mk(K_ERROR, ERR_UNKNOWN, start_ff, 32'd1, line_ff);
                  mode_in = M_DROP;
               end else begin
                  v0 = 1'b1;
                  t0 = mk(K_OP, sc[4:0], start_ff, 32'd1, line_ff);
                  do_fresh = 1'b1;
               end
            end
            M_LINE: if (b == 8'h0a) do_fresh = 1'b1;
            M_BLOCK, M_BLOCK_STAR: begin
               if (mode_ff == M_BLOCK_STAR && b == "/") mode_in = M_IDLE;
               else if (b == "*") mode_in = M_BLOCK_STAR;
               else begin
                  lup = (b == 8'h0a);
                  mode_in = M_BLOCK;
               end
            end
            M_DROP: ;
            default: do_fresh = 1'b1;
         endcase

         // start of a new token at this byte
         if (do_fresh) begin
            mode_in = M_IDLE;
            if (b == " " || b == 8'h09 || b == 8'h0d || b == ";") begin
               // skipped
            end else if (b == 8'h0a) begin
               fv = 1'b1;
               f = mk(K_NEWLINE, 5'd0, pos, 32'd1, line_ff);
               lup = 1'b1;
            end else if (single_code(b) != 6'd0 || b == "&" || b == "|") begin
               held_in = b;
               start_in = pos;
               mode_in = M_OP;
            end else if (yc[5]) begin
               fv = 1'b1;
               f = mk(K_SYMBOL, yc[4:0], pos, 32'd1, line_ff);
            end else if (is_digit(b)) begin
               start_in = pos;
               mode_in = M_NUM_INT;
            end else if (is_alpha(b)) begin
               start_in = pos;
               prefix_in = {40'd0, b};
               wlen_in = 3'd1;
               mode_in = M_IDENT;
            end else begin
               fv = 1'b1;
               f = mk(K_ERROR, ERR_UNKNOWN, pos, 32'd1, line_ff);
               mode_in = M_DROP;
            end
            if (fv) begin
               if (v0) begin
                  v1 = 1'b1;
                  t1 = f;
               end else begin
                  v0 = 1'b1;
                  t0 = f;
               end
            end
         end
         if (lup && line_ff != '1) line_in = line_ff + 1'b1;
      end

      if (v1) t1.last_of_run = 1'b1;
      else t0.last_of_run = 1'b1;
      tok_valid = req_fire ? {v1, v0} : 2'b00;
      tok0 = t0;
      tok1 = t1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= M_IDLE;
         held_ff <= '0;
         pos_ff <= '0;
         start_ff <= '0;
         line_ff <= 32'd1;
         prefix_ff <= '0;
         wlen_ff <= '0;
      end else if (req_fire) begin
         mode_ff <= mode_in;
         held_ff <= held_in;
         pos_ff <= pos_in;
         start_ff <= start_in;
         line_ff <= line_in;
         prefix_ff <= prefix_in;
         wlen_ff <= wlen_in;
      end
   end

   a_second_needs_first: assert property (@(posedge clock) disable iff (reset)
      tok_valid[1] |-> tok_valid[0]) else $error("second token without first");
   a_end_resets: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_item.cmd == CMD_END |=> pos_ff == '0 && line_ff == 32'd1)
      else $error("end command did not restore position and line");
   a_pos_steps: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_item.cmd == CMD_BYTE |=> pos_ff == $past(pos_ff) + 1'b1)
      else $error("byte position did not advance");
   a_line_nonzero: assert property (@(posedge clock) disable iff (reset)
      line_ff != 32'd0) else $error("line count reached zero");

endmodule

[design/stl_queue.sv]
module stl_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [1:0]           push_valid,
   input  stl_pkg::stl_rsp_type push0,
   input  stl_pkg::stl_rsp_type push1,
   output logic                 room2,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output stl_pkg::stl_rsp_type rsp_payload
);
   import stl_pkg::*;

   stl_rsp_type                mem_ff [Q_DEPTH];
   logic [Q_PTR_BITS-1:0]     wr_ff, wr_in, rd_ff, rd_in;
   logic [Q_PTR_BITS:0]       cnt_ff, cnt_in;
   logic                      pop;
   logic [1:0]                npush;

   // pointer and count update
   always_comb begin
      pop = rsp_valid && rsp_ready;
      npush = {1'b0, push_valid[0]} + {1'b0, push_valid[1]};
      wr_in = wr_ff + Q_PTR_BITS'(npush);
      rd_in = rd_ff + Q_PTR_BITS'(pop);
      cnt_in = cnt_ff + (Q_PTR_BITS+1)'(npush) - (Q_PTR_BITS+1)'(pop);
   end

   assign room2 = cnt_ff <= (Q_PTR_BITS+1)'(Q_DEPTH - 2);
   assign rsp_valid = cnt_ff != '0;
   assign rsp_payload = mem_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // token storage
   always_ff @(posedge clock) begin
      if (push_valid[0]) mem_ff[wr_ff] <= push0;
      if (push_valid[1]) mem_ff[wr_ff + 1'b1] <= push1;
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= (Q_PTR_BITS+1)'(Q_DEPTH)) else $error("token queue overflow");
   a_push_has_room: assert property (@(posedge clock) disable iff (reset)
      push_valid != 2'b00 |-> room2) else $error("push without room");
   a_count_tracks: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && push_valid == 2'b00 |=> cnt_ff == $past(cnt_ff) - 1'b1)
      else $error("queue count did not drop on pop");

endmodule

[design/script_token_lexer.sv]
// Script token lexer: one source byte or end command per request.
// Tokens for a request are written into the token queue on acceptance and reach rsp in queue order.
// Throughput: one request per cycle while the four-entry token queue has room
// for two tokens; each request yields up to two tokens, drained one per cycle while rsp_ready is high.
// Reset (synchronous, active high): idle mode, position 0, line 1, queue empty.
module script_token_lexer (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  stl_pkg::stl_req_type req_payload,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output stl_pkg::stl_rsp_type rsp_payload
);
   import stl_pkg::*;

   logic        room2;
   logic        req_fire;
   logic [1:0]  tok_valid;
   stl_rsp_type tok0, tok1;

   assign req_ready = room2;
   assign req_fire = req_valid && req_ready;

   stl_core u_core (
      .clock     (clock),
      .reset     (reset),
      .req_fire  (req_fire),
      .req_item  (req_payload),
      .tok_valid (tok_valid),
      .tok0      (tok0),
      .tok1      (tok1)
   );

   stl_queue u_queue (
      .clock       (clock),
      .reset       (reset),
      .push_valid  (tok_valid),
      .push0       (tok0),
      .push1       (tok1),
      .room2       (room2),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule
